>>> rtl/waypoint_path_follower_macros.svh
// Assertion helpers for the RTL; wpf_alu includes them.
`ifndef WAYPOINT_PATH_FOLLOWER_MACROS_SVH
`define WAYPOINT_PATH_FOLLOWER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define WPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define WPF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WPF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WPF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/wpf_pkg.sv
package wpf_pkg;

    // Waypoint memory depth; the slot and node fields are sized for it
    localparam int MAX_WAYPOINTS = 64;

    // Input commands
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PATH_LENGTH    = 3'd0;
    localparam logic [2:0] REG_CYCLIC_PATH    = 3'd1;
    localparam logic [2:0] REG_ARRIVAL_RADIUS = 3'd2;
    localparam logic [2:0] REG_MIN_SPEED      = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED      = 3'd4;
    localparam logic [2:0] REG_MAX_FORCE      = 3'd5;
    localparam logic [2:0] REG_AGENT_MASS     = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [5:0]         wp_index;
        logic signed [31:0] wp_x;
        logic signed [31:0] wp_y;
        logic signed [31:0] wp_z;
    } wpf_in_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic [6:0]         node_index;
        logic               path_done;
    } wpf_out_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } alu_rsp_t;

endpackage

>>> rtl/wpf_alu.sv
`include "waypoint_path_follower_macros.svh"

// Shared unit: 32x32 multiply, 64/32 restoring divide and 64-bit integer
// square root. All operands unsigned.
module wpf_alu import wpf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_SQRT
    } alu_state_t;

    alu_state_t  state_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] den_reg;
    logic [63:0] res_reg;
    logic        done_reg;

    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_rem;
    logic [34:0] sq_sh;
    logic [34:0] sq_trial;
    logic        sq_ge;
    logic [34:0] sq_rem;

    always_comb begin
        div_sh   = {rem_reg[31:0], acc_reg[63]};
        div_ge   = div_sh >= {1'b0, den_reg};
        div_rem  = div_ge ? div_sh - {1'b0, den_reg} : div_sh;
        sq_sh    = {rem_reg[32:0], acc_reg[63:62]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        unique case (req.op)
                            ALU_MUL: begin
                                res_reg  <= 64'(req.a[31:0]) * 64'(req.b);
                                done_reg <= 1'b1;
                            end
                            ALU_DIV: begin
                                acc_reg   <= req.a;
                                den_reg   <= req.b;
                                rem_reg   <= '0;
                                state_reg <= A_DIV;
                            end
                            ALU_SQRT: begin
                                acc_reg   <= req.a;
                                rem_reg   <= '0;
                                root_reg  <= '0;
                                state_reg <= A_SQRT;
                            end
                            default: begin
                                res_reg  <= '0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    rem_reg <= 35'(div_rem);
                    acc_reg <= {acc_reg[62:0], div_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                        res_reg   <= {acc_reg[62:0], div_ge};
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_SQRT: begin
                    rem_reg  <= sq_rem;
                    root_reg <= {root_reg[30:0], sq_ge};
                    acc_reg  <= {acc_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQRT_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        res_reg   <= {32'd0, root_reg[30:0], sq_ge};
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    `WPF_ASSERT_IMP(a_start_idle, aclk, aresetn, req.start, state_reg == A_IDLE)
    `WPF_ASSERT_NXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg)
    `WPF_ASSERT_IMP(a_cnt_idle, aclk, aresetn, state_reg == A_IDLE, cnt_reg == 6'd0)

endmodule

>>> rtl/waypoint_path_follower.sv
// A step needs up to thirteen divides, three square roots and up to nineteen multiplies,
// all on the one shared arithmetic unit; a finished or empty path skips them and goes
// straight to the result state. One transaction is in work at a time, and a result
// still held by the receiver stalls the sequencer in its last state.
// aresetn (synchronous, active low) resets control, the configuration registers and the
// node index; the waypoint memory keeps its contents and is undefined until loaded.
module waypoint_path_follower import wpf_pkg::*; #(
    parameter int FRAC_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  wpf_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output wpf_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam logic signed [33:0] S32_MAX34 = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN34 = -34'sd2147483648;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD,
        ST_SQ_MUL, ST_SQ_WAIT, ST_RT_ISSUE, ST_RT_WAIT,
        ST_M_MUL, ST_M_MULW, ST_M_DIV, ST_M_DIVW,
        ST_DS_MUL, ST_DS_MULW, ST_DS_DIV, ST_DS_DIVW,
        ST_LIM_MUL, ST_LIM_MULW, ST_LIM_DIV, ST_LIM_DIVW,
        ST_MS_DIV, ST_MS_DIVW,
        ST_FIN
    } state_t;

    // Which vector length is in work
    typedef enum logic [1:0] {
        P_DIST,
        P_FORCE,
        P_SPEED
    } phase_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > S32_MAX34) begin
            return 32'sh7fffffff;
        end else if (v < S32_MIN34) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Configuration registers
    logic [6:0]  path_length_reg;
    logic        cyclic_path_reg;
    logic [30:0] arrival_radius_reg;
    logic [30:0] min_speed_reg;
    logic [30:0] max_speed_reg;
    logic [30:0] max_force_reg;
    logic [30:0] agent_mass_reg;

    // Waypoint memory: {x, y, z}
    logic [95:0]   wp_mem [MAX_WAYPOINTS];
    logic [95:0]   rd_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    state_t             state_reg;
    phase_t             phase_reg;
    logic [6:0]         node_reg;
    logic [1:0]         i_reg;
    logic               neg_reg;
    logic               done_flag_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        dist_reg;
    logic [31:0]        len_reg;
    logic [31:0]        m_reg;
    logic [30:0]        lim_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] d_reg   [3];
    logic signed [31:0] s_reg   [3];
    logic               m_valid_reg;
    wpf_out_t           m_data_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [6:0]         eff_len;
    logic               s_accept;
    logic               path_finished;
    logic signed [31:0] vsel;
    logic [31:0]        vmag;
    logic signed [31:0] diff;
    logic [31:0]        diff_mag;
    logic [31:0]        mass_eff;
    logic [6:0]         node_inc;
    logic signed [33:0] q_signed;
    logic signed [31:0] mass_q;
    logic [31:0]        q32;

    wpf_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    always_comb begin
        // A path longer than the memory counts as full memory
        eff_len = (32'(path_length_reg) > MAX_WAYPOINTS) ? 7'(MAX_WAYPOINTS) : path_length_reg;
        path_finished = (eff_len == 7'd0) || (node_reg >= eff_len);
        s_ready  = (state_reg == ST_IDLE);
        s_accept = s_valid && s_ready;
        vsel     = (phase_reg == P_DIST) ? d_reg[i_reg] : s_reg[i_reg];
        vmag     = vsel[31] ? 32'(-vsel) : 32'(vsel);
        diff     = $signed({1'b0, max_speed_reg}) - $signed({1'b0, min_speed_reg});
        diff_mag = diff[31] ? 32'(-diff) : 32'(diff);
        mass_eff = (agent_mass_reg == 31'd0) ? 32'd1 : {1'b0, agent_mass_reg};
        node_inc = node_reg + 7'd1;
        q32      = alu_rsp.res[31:0];
        // Signed value of a small quotient
        q_signed = neg_reg ? -$signed({2'b00, q32}) : $signed({2'b00, q32});
        // Saturate the mass quotient, which can reach far past 32 bits
        if (!neg_reg) begin
            mass_q = (alu_rsp.res > 64'h7fffffff) ? 32'sh7fffffff : $signed(q32);
        end else begin
            mass_q = (alu_rsp.res > 64'h80000000) ? 32'sh80000000 : -$signed(q32);
        end
        rd_addr = AW'(node_reg);
        wr_addr = AW'(s_data.wp_index);
        wr_en   = s_accept && (s_data.cmd == CMD_LOAD)
                  && (32'(s_data.wp_index) < MAX_WAYPOINTS);
    end

    // Drive the shared unit from the sequencer state
    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_SQ_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = {32'd0, vmag};
                alu_req.b     = vmag;
            end
            ST_RT_ISSUE: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_req.a     = acc_reg;
            end
            ST_M_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = {32'd0, diff_mag};
                alu_req.b     = dist_reg;
            end
            ST_M_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = prod_reg;
                alu_req.b     = {1'b0, arrival_radius_reg};
            end
            ST_DS_MUL: begin
                alu_req.start = (dist_reg != 32'd0);
                alu_req.op    = ALU_MUL;
                alu_req.a     = {32'd0, vmag};
                alu_req.b     = m_reg;
            end
            ST_DS_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = prod_reg;
                alu_req.b     = dist_reg;
            end
            ST_LIM_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = {32'd0, vmag};
                alu_req.b     = {1'b0, lim_reg};
            end
            ST_LIM_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = prod_reg;
                alu_req.b     = len_reg;
            end
            ST_MS_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = 64'(vmag) << FRAC_BITS;
                alu_req.b     = mass_eff;
            end
            default: alu_req = '0;
        endcase
    end

    // Waypoint memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wp_mem[wr_addr] <= {s_data.wp_x, s_data.wp_y, s_data.wp_z};
        end
        rd_reg <= wp_mem[rd_addr];
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_length_reg    <= '0;
            cyclic_path_reg    <= 1'b0;
            arrival_radius_reg <= 31'(1) << FRAC_BITS;
            min_speed_reg      <= '0;
            max_speed_reg      <= 31'(1) << FRAC_BITS;
            max_force_reg      <= 31'(1) << FRAC_BITS;
            agent_mass_reg     <= 31'(1) << FRAC_BITS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATH_LENGTH:    path_length_reg    <= cfg_data[6:0];
                REG_CYCLIC_PATH:    cyclic_path_reg    <= cfg_data[0];
                REG_ARRIVAL_RADIUS: arrival_radius_reg <= cfg_data[30:0];
                REG_MIN_SPEED:      min_speed_reg      <= cfg_data[30:0];
                REG_MAX_SPEED:      max_speed_reg      <= cfg_data[30:0];
                REG_MAX_FORCE:      max_force_reg      <= cfg_data[30:0];
                REG_AGENT_MASS:     agent_mass_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Step sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= P_DIST;
            node_reg      <= '0;
            i_reg         <= '0;
            done_flag_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the held result once the transaction is taken, unless a new one
            // replaces it in the same cycle
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        priority if (s_data.cmd == CMD_START) begin
                            node_reg <= '0;
                        end else if (s_data.cmd == CMD_STEP) begin
                            pos_reg[0] <= s_data.pos_x;
                            pos_reg[1] <= s_data.pos_y;
                            pos_reg[2] <= s_data.pos_z;
                            vel_reg[0] <= s_data.vel_x;
                            vel_reg[1] <= s_data.vel_y;
                            vel_reg[2] <= s_data.vel_z;
                            if (path_finished) begin
                                // Zero velocity, flag the end of the path
                                for (int k = 0; k < 3; k++) begin
                                    s_reg[k] <= '0;
                                end
                                done_flag_reg <= 1'b1;
                                state_reg     <= ST_FIN;
                            end else begin
                                done_flag_reg <= 1'b0;
                                state_reg     <= ST_RD;
                            end
                        end else begin
                        end
                    end
                end
                ST_RD: begin
                    d_reg[0]  <= sat32(34'($signed(rd_reg[95:64])) - 34'(pos_reg[0]));
                    d_reg[1]  <= sat32(34'($signed(rd_reg[63:32])) - 34'(pos_reg[1]));
                    d_reg[2]  <= sat32(34'($signed(rd_reg[31:0]))  - 34'(pos_reg[2]));
                    phase_reg <= P_DIST;
                    acc_reg   <= '0;
                    i_reg     <= '0;
                    state_reg <= ST_SQ_MUL;
                end
                ST_SQ_MUL: state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT: begin
                    if (alu_rsp.done) begin
                        acc_reg <= acc_reg + alu_rsp.res;
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            state_reg <= ST_RT_ISSUE;
                        end else begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= ST_SQ_MUL;
                        end
                    end
                end
                ST_RT_ISSUE: state_reg <= ST_RT_WAIT;
                ST_RT_WAIT: begin
                    if (alu_rsp.done) begin
                        len_reg <= q32;
                        unique case (phase_reg)
                            P_DIST: begin
                                dist_reg <= q32;
                                if (q32 < {1'b0, arrival_radius_reg}) begin
                                    // Reached: advance, wrap on a cyclic path
                                    if (cyclic_path_reg && node_inc == eff_len) begin
                                        node_reg <= '0;
                                    end else begin
                                        node_reg <= node_inc;
                                    end
                                    state_reg <= ST_M_MUL;
                                end else begin
                                    m_reg     <= {1'b0, max_speed_reg};
                                    state_reg <= ST_DS_MUL;
                                end
                            end
                            P_FORCE: begin
                                lim_reg <= max_force_reg;
                                state_reg <= (q32 > {1'b0, max_force_reg}) ? ST_LIM_MUL
                                                                            : ST_MS_DIV;
                            end
                            P_SPEED: begin
                                lim_reg <= max_speed_reg;
                                state_reg <= (q32 > {1'b0, max_speed_reg}) ? ST_LIM_MUL
                                                                            : ST_FIN;
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                // Arrival slowing: m = min + (max - min) * dist / radius
                ST_M_MUL: begin
                    neg_reg   <= diff[31];
                    state_reg <= ST_M_MULW;
                end
                ST_M_MULW: begin
                    if (alu_rsp.done) begin
                        prod_reg  <= alu_rsp.res;
                        state_reg <= ST_M_DIV;
                    end
                end
                ST_M_DIV: state_reg <= ST_M_DIVW;
                ST_M_DIVW: begin
                    if (alu_rsp.done) begin
                        m_reg     <= 32'($signed({3'b000, min_speed_reg}) + q_signed);
                        state_reg <= ST_DS_MUL;
                    end
                end
                // Desired velocity minus current velocity, per component
                ST_DS_MUL: begin
                    if (dist_reg == 32'd0) begin
                        s_reg[i_reg] <= sat32(34'sd0 - 34'(vel_reg[i_reg]));
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            phase_reg <= P_FORCE;
                            state_reg <= ST_SQ_MUL;
                        end else begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end else begin
                        neg_reg   <= vsel[31];
                        state_reg <= ST_DS_MULW;
                    end
                end
                ST_DS_MULW: begin
                    if (alu_rsp.done) begin
                        prod_reg  <= alu_rsp.res;
                        state_reg <= ST_DS_DIV;
                    end
                end
                ST_DS_DIV: state_reg <= ST_DS_DIVW;
                ST_DS_DIVW: begin
                    if (alu_rsp.done) begin
                        s_reg[i_reg] <= sat32(q_signed - 34'(vel_reg[i_reg]));
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            phase_reg <= P_FORCE;
                            state_reg <= ST_SQ_MUL;
                        end else begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= ST_DS_MUL;
                        end
                    end
                end
                // Scale the vector down to lim_reg
                ST_LIM_MUL: begin
                    neg_reg   <= vsel[31];
                    state_reg <= ST_LIM_MULW;
                end
                ST_LIM_MULW: begin
                    if (alu_rsp.done) begin
                        prod_reg  <= alu_rsp.res;
                        state_reg <= ST_LIM_DIV;
                    end
                end
                ST_LIM_DIV: state_reg <= ST_LIM_DIVW;
                ST_LIM_DIVW: begin
                    if (alu_rsp.done) begin
                        s_reg[i_reg] <= q_signed[31:0];
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            state_reg <= (phase_reg == P_FORCE) ? ST_MS_DIV : ST_FIN;
                        end else begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= ST_LIM_MUL;
                        end
                    end
                end
                // Divide steering by mass and add to the velocity
                ST_MS_DIV: begin
                    neg_reg   <= vsel[31];
                    state_reg <= ST_MS_DIVW;
                end
                ST_MS_DIVW: begin
                    if (alu_rsp.done) begin
                        s_reg[i_reg] <= sat32(34'(vel_reg[i_reg]) + 34'(mass_q));
                        if (i_reg == 2'd2) begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            phase_reg <= P_SPEED;
                            state_reg <= ST_SQ_MUL;
                        end else begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= ST_MS_DIV;
                        end
                    end
                end
                // Hold until the output register is free
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.new_vel_x  <= s_reg[0];
                        m_data_reg.new_vel_y  <= s_reg[1];
                        m_data_reg.new_vel_z  <= s_reg[2];
                        m_data_reg.node_index <= node_reg;
                        m_data_reg.path_done  <= done_flag_reg;
                        m_valid_reg           <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
